>>> hw/rtl/chiptune_player_bus_decoder_defines.svh
// Assertion helpers for the decoder RTL.
`ifndef CHIPTUNE_PLAYER_BUS_DECODER_DEFINES_SVH
`define CHIPTUNE_PLAYER_BUS_DECODER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define CPBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define CPBD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/cpbd_pkg.sv
`default_nettype none

package cpbd_pkg;

  // Field widths
  localparam int CMD_W         = 2;
  localparam int ADDR_W        = 16;
  localparam int BYTE_W        = 8;
  localparam int ROUTE_W       = 4;
  localparam int SLOT_W        = 4;
  localparam int STUB_OFF_W    = 5;
  localparam int CHIP_MASK_W   = 6;
  localparam int PERIOD_W      = 16;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 16;

  // Bus commands
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CHIP_MASK    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PLAY_PERIOD  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INIT_ADDRESS = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PLAY_ADDRESS = 2'd3;

  // Configuration reset values
  localparam logic [PERIOD_W-1:0] PLAY_PERIOD_RESET = 16'd29780;
  localparam logic [ADDR_W-1:0]   ENTRY_ADDR_RESET  = 16'h8000;

  // Route codes
  localparam logic [ROUTE_W-1:0] ROUTE_HERE  = 4'd0;
  localparam logic [ROUTE_W-1:0] ROUTE_DISK  = 4'd1;
  localparam logic [ROUTE_W-1:0] ROUTE_WTBL  = 4'd2;
  localparam logic [ROUTE_W-1:0] ROUTE_EXTP  = 4'd3;
  localparam logic [ROUTE_W-1:0] ROUTE_PSG   = 4'd4;
  localparam logic [ROUTE_W-1:0] ROUTE_PULSE = 4'd5;
  localparam logic [ROUTE_W-1:0] ROUTE_FM    = 4'd6;
  localparam logic [ROUTE_W-1:0] ROUTE_STUB  = 4'd7;
  localparam logic [ROUTE_W-1:0] ROUTE_NONE  = 4'd8;

  // Sound chip enable bit positions in chip_mask
  localparam int CHIP_PULSE = 0;
  localparam int CHIP_FM    = 1;
  localparam int CHIP_DISK  = 2;
  localparam int CHIP_EXTP  = 3;
  localparam int CHIP_WTBL  = 4;
  localparam int CHIP_PSG   = 5;

  // Address map
  localparam logic [ADDR_W-1:0] STUB_FIRST   = 16'h3F00;
  localparam logic [ADDR_W-1:0] STUB_LAST    = 16'h3F1F;
  localparam logic [ADDR_W-1:0] IRQ_ACK_ADDR = 16'h3F00;
  localparam logic [ADDR_W-1:0] DISK_FIRST   = 16'h4040;
  localparam logic [ADDR_W-1:0] DISK_LAST    = 16'h4092;
  localparam logic [ADDR_W-1:0] WTBL_FIRST   = 16'h4800;
  localparam logic [ADDR_W-1:0] WTBL_LAST    = 16'h4FFF;
  localparam logic [ADDR_W-1:0] WTBL_HIGH    = 16'hF800;
  localparam logic [ADDR_W-1:0] EXTP_FIRST   = 16'h5000;
  localparam logic [ADDR_W-1:0] EXTP_LAST    = 16'h5015;
  localparam logic [ADDR_W-1:0] MULT_LO_ADDR = 16'h5205;
  localparam logic [ADDR_W-1:0] MULT_HI_ADDR = 16'h5206;
  localparam logic [ADDR_W-1:0] MAP_FIRST    = 16'h5FF6;
  localparam logic [ADDR_W-1:0] MAP_LAST_RW  = 16'h5FFD;
  localparam logic [ADDR_W-1:0] MAP_LAST     = 16'h5FFF;
  localparam logic [ADDR_W-1:0] PSG_FIRST    = 16'hC000;
  localparam logic [ADDR_W-1:0] PULSE1_FIRST = 16'h9000;
  localparam logic [ADDR_W-1:0] PULSE1_LAST  = 16'h9003;
  localparam logic [ADDR_W-1:0] PULSE2_FIRST = 16'hA000;
  localparam logic [ADDR_W-1:0] PULSE2_LAST  = 16'hA002;
  localparam logic [ADDR_W-1:0] PULSE3_FIRST = 16'hB000;
  localparam logic [ADDR_W-1:0] PULSE3_LAST  = 16'hB002;
  localparam logic [ADDR_W-1:0] FM_ADDR_A    = 16'h9010;
  localparam logic [ADDR_W-1:0] FM_ADDR_B    = 16'h9030;
  localparam logic [ADDR_W-1:0] VEC_RESET_LO = 16'hFFFC;
  localparam logic [ADDR_W-1:0] VEC_RESET_HI = 16'hFFFD;
  localparam logic [ADDR_W-1:0] VEC_IRQ_LO   = 16'hFFFE;
  localparam logic [ADDR_W-1:0] VEC_IRQ_HI   = 16'hFFFF;

  // Fixed vector bytes: reset and IRQ both point into the stub
  localparam logic [BYTE_W-1:0] VEC_RESET_LO_BYTE = 8'h00;
  localparam logic [BYTE_W-1:0] VEC_RESET_HI_BYTE = 8'h3F;
  localparam logic [BYTE_W-1:0] VEC_IRQ_LO_BYTE   = 8'h10;
  localparam logic [BYTE_W-1:0] VEC_IRQ_HI_BYTE   = 8'h3F;

  // Patched byte offsets inside the player stub
  localparam logic [STUB_OFF_W-1:0] STUB_INIT_LO  = 5'h02;
  localparam logic [STUB_OFF_W-1:0] STUB_INIT_HI  = 5'h03;
  localparam logic [STUB_OFF_W-1:0] STUB_PLAY_LO  = 5'h05;
  localparam logic [STUB_OFF_W-1:0] STUB_PLAY_HI  = 5'h06;
  localparam logic [STUB_OFF_W-1:0] STUB_PLAY2_LO = 5'h14;
  localparam logic [STUB_OFF_W-1:0] STUB_PLAY2_HI = 5'h15;

  // Slots below this are always writable (the 0x6000-0x7FFF RAM windows)
  localparam logic [SLOT_W-1:0] MAP_ALWAYS_RW_SLOTS = 4'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] bus_addr;
    logic [BYTE_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [CHIP_MASK_W-1:0] chip_mask;
    logic [PERIOD_W-1:0]    play_period;
    logic [ADDR_W-1:0]      init_address;
    logic [ADDR_W-1:0]      play_address;
  } cfg_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] play_countdown;
    logic                irq_pending;
    logic [BYTE_W-1:0]   mult_left;
    logic [BYTE_W-1:0]   mult_right;
  } state_t;

  typedef struct packed {
    logic [ROUTE_W-1:0]    route;
    logic [BYTE_W-1:0]     read_data;
    logic                  irq_line;
    logic                  map_valid;
    logic [SLOT_W-1:0]     map_slot;
    logic [BYTE_W-1:0]     map_bank;
    logic                  map_writable;
    logic [STUB_OFF_W-1:0] stub_offset;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/cpbd_if.sv
`default_nettype none

// Request channel: one bus cycle per beat
interface cpbd_req_if import cpbd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] bus_addr;
  logic [BYTE_W-1:0] write_data;

  modport source (output valid, output command, output bus_addr, output write_data,
                  input ready);
  modport sink   (input valid, input command, input bus_addr, input write_data,
                  output ready);
endinterface

// Response channel: one decode result per beat
interface cpbd_rsp_if import cpbd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [ROUTE_W-1:0]    route;
  logic [BYTE_W-1:0]     read_data;
  logic                  irq_line;
  logic                  map_valid;
  logic [SLOT_W-1:0]     map_slot;
  logic [BYTE_W-1:0]     map_bank;
  logic                  map_writable;
  logic [STUB_OFF_W-1:0] stub_offset;

  modport source (output valid, output route, output read_data, output irq_line,
                  output map_valid, output map_slot, output map_bank,
                  output map_writable, output stub_offset, input ready);
  modport sink   (input valid, input route, input read_data, input irq_line,
                  input map_valid, input map_slot, input map_bank,
                  input map_writable, input stub_offset, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/cpbd_decode.sv
`default_nettype none

// Combinational decode of one bus cycle against the current mapper state.
module cpbd_decode import cpbd_pkg::*; (
  input  item_t   item,
  input  cfg_t    cfg,
  input  state_t  state,
  output result_t result,
  output state_t  state_next
);

  logic has_pulse, has_fm, has_disk, has_extp, has_wtbl, has_psg;

  assign has_pulse = cfg.chip_mask[CHIP_PULSE];
  assign has_fm    = cfg.chip_mask[CHIP_FM];
  assign has_disk  = cfg.chip_mask[CHIP_DISK];
  assign has_extp  = cfg.chip_mask[CHIP_EXTP];
  assign has_wtbl  = cfg.chip_mask[CHIP_WTBL];
  assign has_psg   = cfg.chip_mask[CHIP_PSG];

  always_comb begin
    logic [ADDR_W-1:0]     a;
    logic [PERIOD_W-1:0]   count_dec;
    logic [2*BYTE_W-1:0]   prod;
    logic [STUB_OFF_W-1:0] off;
    logic [SLOT_W-1:0]     slot;

    a          = item.bus_addr;
    count_dec  = state.play_countdown - PERIOD_W'(1);
    prod       = state.mult_left * state.mult_right;
    off        = a[STUB_OFF_W-1:0];
    slot       = a[SLOT_W-1:0] - MAP_FIRST[SLOT_W-1:0];

    state_next   = state;
    result       = '0;
    result.route = ROUTE_NONE;

    unique case (item.command)
      // Count down; reload and raise the play interrupt at zero
      CMD_TICK: begin
        result.route = ROUTE_HERE;
        if (count_dec == '0) begin
          state_next.play_countdown = cfg.play_period;
          state_next.irq_pending    = 1'b1;
        end else begin
          state_next.play_countdown = count_dec;
        end
      end

      CMD_READ: begin
        priority if (has_disk && a >= DISK_FIRST && a <= DISK_LAST) begin
          result.route = ROUTE_DISK;
        end else if (has_wtbl && a >= WTBL_FIRST && a <= WTBL_LAST) begin
          result.route = ROUTE_WTBL;
        end else if (a >= STUB_FIRST && a <= STUB_LAST) begin
          // Patch the entry addresses, fetch the rest from the stub ROM
          result.route = ROUTE_HERE;
          unique case (off)
            STUB_INIT_LO:                 result.read_data = cfg.init_address[7:0];
            STUB_INIT_HI:                 result.read_data = cfg.init_address[15:8];
            STUB_PLAY_LO, STUB_PLAY2_LO:  result.read_data = cfg.play_address[7:0];
            STUB_PLAY_HI, STUB_PLAY2_HI:  result.read_data = cfg.play_address[15:8];
            default: begin
              result.route       = ROUTE_STUB;
              result.stub_offset = off;
            end
          endcase
        end else if (has_extp && a == MULT_LO_ADDR) begin
          result.route     = ROUTE_HERE;
          result.read_data = prod[BYTE_W-1:0];
        end else if (has_extp && a == MULT_HI_ADDR) begin
          result.route     = ROUTE_HERE;
          result.read_data = prod[2*BYTE_W-1:BYTE_W];
        end else if (a == VEC_RESET_LO) begin
          result.route     = ROUTE_HERE;
          result.read_data = VEC_RESET_LO_BYTE;
        end else if (a == VEC_RESET_HI) begin
          result.route     = ROUTE_HERE;
          result.read_data = VEC_RESET_HI_BYTE;
        end else if (a == VEC_IRQ_LO) begin
          result.route     = ROUTE_HERE;
          result.read_data = VEC_IRQ_LO_BYTE;
        end else if (a == VEC_IRQ_HI) begin
          result.route     = ROUTE_HERE;
          result.read_data = VEC_IRQ_HI_BYTE;
        end else begin
          result.route = ROUTE_NONE;
        end
      end

      CMD_WRITE: begin
        priority if (has_disk && a >= DISK_FIRST && a <= DISK_LAST) begin
          result.route = ROUTE_DISK;
        end else if (has_extp && a >= EXTP_FIRST && a <= EXTP_LAST) begin
          result.route = ROUTE_EXTP;
        end else if (has_wtbl && ((a >= WTBL_FIRST && a <= WTBL_LAST) ||
                                  a >= WTBL_HIGH)) begin
          result.route = ROUTE_WTBL;
        end else if (has_psg && a >= PSG_FIRST) begin
          result.route = ROUTE_PSG;
        end else if (a == IRQ_ACK_ADDR) begin
          result.route           = ROUTE_HERE;
          state_next.irq_pending = 1'b0;
        end else if (has_extp && a == MULT_LO_ADDR) begin
          result.route         = ROUTE_HERE;
          state_next.mult_left = item.write_data;
        end else if (has_extp && a == MULT_HI_ADDR) begin
          result.route          = ROUTE_HERE;
          state_next.mult_right = item.write_data;
        end else if (a >= MAP_FIRST && a <= MAP_LAST) begin
          // Emit a bank mapping event for the addressed 4 KB slot
          result.route        = ROUTE_HERE;
          result.map_valid    = 1'b1;
          result.map_slot     = slot;
          result.map_bank     = item.write_data;
          result.map_writable = (slot < MAP_ALWAYS_RW_SLOTS) ||
                                (a <= MAP_LAST_RW && has_disk);
        end else if (has_pulse && ((a >= PULSE1_FIRST && a <= PULSE1_LAST) ||
                                   (a >= PULSE2_FIRST && a <= PULSE2_LAST) ||
                                   (a >= PULSE3_FIRST && a <= PULSE3_LAST))) begin
          result.route = ROUTE_PULSE;
        end else if (has_fm && (a == FM_ADDR_A || a == FM_ADDR_B)) begin
          result.route = ROUTE_FM;
        end else begin
          result.route = ROUTE_NONE;
        end
      end

      // Unused command code: nothing changes, nothing claims it
      default: result.route = ROUTE_NONE;
    endcase

    result.irq_line = state_next.irq_pending;
  end

endmodule

`default_nettype wire

>>> hw/rtl/chiptune_player_bus_decoder.sv
`default_nettype none

`include "chiptune_player_bus_decoder_defines.svh"

// Music-player cartridge bus decoder. Each request beat is one CPU cycle (tick,
// read or write); each one yields exactly one response beat. Throughput is one
// beat per clock while the response side is not stalled: a request lands in an
// input register, the decode, the play-rate countdown and the 8x8 product are
// evaluated in the single logic stage after it, and the result sits in an
// output register that may stall while the next request is already held.
// irq_line in each response is the interrupt level after that cycle.
// Configuration writes take effect at once and are meant to be issued only
// while no request is in flight; a new play_period is picked up at the next
// countdown reload. No memory, so there is no clearing pass.
module chiptune_player_bus_decoder import cpbd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  cpbd_req_if.sink               req,
  cpbd_rsp_if.source             rsp,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_result;
  result_t result_next;
  logic    out_free;
  logic    advance;

  // Move a held request into the result register when that slot frees up
  assign out_free  = !out_valid || rsp.ready;
  assign advance   = in_valid && out_free;
  assign req.ready = !in_valid || advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chip_mask    <= '0;
      cfg.play_period  <= PLAY_PERIOD_RESET;
      cfg.init_address <= ENTRY_ADDR_RESET;
      cfg.play_address <= ENTRY_ADDR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHIP_MASK:    cfg.chip_mask    <= cfg_data[CHIP_MASK_W-1:0];
        REG_PLAY_PERIOD:  cfg.play_period  <= cfg_data[PERIOD_W-1:0];
        REG_INIT_ADDRESS: cfg.init_address <= cfg_data[ADDR_W-1:0];
        REG_PLAY_ADDRESS: cfg.play_address <= cfg_data[ADDR_W-1:0];
      endcase
    end
  end

  // Input register: capture a beat whenever the slot is free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_item.command    <= req.command;
      in_item.bus_addr   <= req.bus_addr;
      in_item.write_data <= req.write_data;
    end
  end

  cpbd_decode u_decode (
    .item       (in_item),
    .cfg        (cfg),
    .state      (state),
    .result     (result_next),
    .state_next (state_next)
  );

  // Mapper state commits together with the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state.play_countdown <= PLAY_PERIOD_RESET;
      state.irq_pending    <= 1'b0;
      state.mult_left      <= '0;
      state.mult_right     <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register: hold while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.route        = out_result.route;
  assign rsp.read_data    = out_result.read_data;
  assign rsp.irq_line     = out_result.irq_line;
  assign rsp.map_valid    = out_result.map_valid;
  assign rsp.map_slot     = out_result.map_slot;
  assign rsp.map_bank     = out_result.map_bank;
  assign rsp.map_writable = out_result.map_writable;
  assign rsp.stub_offset  = out_result.stub_offset;

  // Checks
  `CPBD_ASSERT_ALWAYS(a_rst_empties_output, rst |=> !rsp.valid, "output valid after reset")
  `CPBD_ASSERT(a_advance_fills_output, advance |=> rsp.valid, "advanced beat not presented")
  `CPBD_ASSERT(a_irq_clear_only_by_ack,
               ($past(!rst) && $past(state.irq_pending) && !state.irq_pending) |->
               $past(advance && in_item.command == CMD_WRITE &&
                     in_item.bus_addr == IRQ_ACK_ADDR),
               "play interrupt dropped without an acknowledge write")
  `CPBD_ASSERT(a_countdown_only_on_tick,
               ($past(!rst) && !$stable(state.play_countdown)) |->
               $past(advance && in_item.command == CMD_TICK),
               "countdown moved without a tick")

endmodule

`default_nettype wire

>>> sim/tb.sv
`default_nettype none

module tb;
  import cpbd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 3;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 8;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_CYCLES  = 50;
  localparam longint RUN_LIMIT_NS = 64'd1_000_000;

  // Command code outside the three defined bus commands
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  cpbd_req_if cpu_req ();
  cpbd_rsp_if dec_rsp ();

  chiptune_player_bus_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .req       (cpu_req),
    .rsp       (dec_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Mirror of the cartridge registers and state
  cfg_t   regs;
  state_t cart;

  item_t   cpu_cycles_todo[$];
  result_t predicted_decodes[$];

  logic calm;
  logic hold_arm;
  int   mismatches;
  int   decodes_checked;
  int   irq_rises;
  int   bank_maps;
  int   settings_used;

  // Work out the decode of one CPU cycle and advance the mirrored state
  function automatic result_t decode_cpu_cycle(item_t c);
    result_t r;
    logic [15:0] a;
    logic [15:0] prod;
    logic [15:0] slot;
    logic [STUB_OFF_W-1:0] off;
    r = '0;
    a = c.bus_addr;
    prod = cart.mult_left * cart.mult_right;
    off = a[STUB_OFF_W-1:0];
    case (c.command)
      CMD_TICK: begin
        cart.play_countdown = cart.play_countdown - 1'b1;
        if (cart.play_countdown == '0) begin
          cart.play_countdown = regs.play_period;
          cart.irq_pending = 1'b1;
        end
        r.route = ROUTE_HERE;
      end
      CMD_READ: begin
        if (regs.chip_mask[CHIP_DISK] && a >= DISK_FIRST && a <= DISK_LAST) begin
          r.route = ROUTE_DISK;
        end else if (regs.chip_mask[CHIP_WTBL] && a >= WTBL_FIRST && a <= WTBL_LAST) begin
          r.route = ROUTE_WTBL;
        end else if (a >= STUB_FIRST && a <= STUB_LAST) begin
          r.route = ROUTE_HERE;
          case (off)
            STUB_INIT_LO: r.read_data = regs.init_address[7:0];
            STUB_INIT_HI: r.read_data = regs.init_address[15:8];
            STUB_PLAY_LO, STUB_PLAY2_LO: r.read_data = regs.play_address[7:0];
            STUB_PLAY_HI, STUB_PLAY2_HI: r.read_data = regs.play_address[15:8];
            default: begin
              r.route = ROUTE_STUB;
              r.stub_offset = off;
            end
          endcase
        end else if (regs.chip_mask[CHIP_EXTP] && a == MULT_LO_ADDR) begin
          r.route = ROUTE_HERE;
          r.read_data = prod[7:0];
        end else if (regs.chip_mask[CHIP_EXTP] && a == MULT_HI_ADDR) begin
          r.route = ROUTE_HERE;
          r.read_data = prod[15:8];
        end else begin
          r.route = ROUTE_HERE;
          case (a)
            VEC_RESET_LO: r.read_data = VEC_RESET_LO_BYTE;
            VEC_RESET_HI: r.read_data = VEC_RESET_HI_BYTE;
            VEC_IRQ_LO:   r.read_data = VEC_IRQ_LO_BYTE;
            VEC_IRQ_HI:   r.read_data = VEC_IRQ_HI_BYTE;
            default:      r.route = ROUTE_NONE;
          endcase
        end
      end
      CMD_WRITE: begin
        if (regs.chip_mask[CHIP_DISK] && a >= DISK_FIRST && a <= DISK_LAST) begin
          r.route = ROUTE_DISK;
        end else if (regs.chip_mask[CHIP_EXTP] && a >= EXTP_FIRST && a <= EXTP_LAST) begin
          r.route = ROUTE_EXTP;
        end else if (regs.chip_mask[CHIP_WTBL] &&
                     ((a >= WTBL_FIRST && a <= WTBL_LAST) || a >= WTBL_HIGH)) begin
          r.route = ROUTE_WTBL;
        end else if (regs.chip_mask[CHIP_PSG] && a >= PSG_FIRST) begin
          r.route = ROUTE_PSG;
        end else if (a == IRQ_ACK_ADDR) begin
          cart.irq_pending = 1'b0;
          r.route = ROUTE_HERE;
        end else if (regs.chip_mask[CHIP_EXTP] && a == MULT_LO_ADDR) begin
          cart.mult_left = c.write_data;
          r.route = ROUTE_HERE;
        end else if (regs.chip_mask[CHIP_EXTP] && a == MULT_HI_ADDR) begin
          cart.mult_right = c.write_data;
          r.route = ROUTE_HERE;
        end else if (a >= MAP_FIRST && a <= MAP_LAST) begin
          slot = a - MAP_FIRST;
          r.route = ROUTE_HERE;
          r.map_valid = 1'b1;
          r.map_slot = slot[SLOT_W-1:0];
          r.map_bank = c.write_data;
          r.map_writable = (slot[SLOT_W-1:0] < MAP_ALWAYS_RW_SLOTS) ||
                           (a <= MAP_LAST_RW && regs.chip_mask[CHIP_DISK]);
          bank_maps++;
        end else if (regs.chip_mask[CHIP_PULSE] &&
                     ((a >= PULSE1_FIRST && a <= PULSE1_LAST) ||
                      (a >= PULSE2_FIRST && a <= PULSE2_LAST) ||
                      (a >= PULSE3_FIRST && a <= PULSE3_LAST))) begin
          r.route = ROUTE_PULSE;
        end else if (regs.chip_mask[CHIP_FM] && (a == FM_ADDR_A || a == FM_ADDR_B)) begin
          r.route = ROUTE_FM;
        end else begin
          r.route = ROUTE_NONE;
        end
      end
      default: r.route = ROUTE_NONE;
    endcase
    r.irq_line = cart.irq_pending;
    return r;
  endfunction

  // Pick a CPU cycle, aiming the address at the decoder's windows and their edges
  function automatic item_t random_cpu_cycle();
    item_t c;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 6) begin
      c.command = CMD_TICK;
    end else if (pick < 13) begin
      c.command = CMD_READ;
    end else if (pick < 19) begin
      c.command = CMD_WRITE;
    end else begin
      c.command = CMD_UNUSED;
    end
    c.write_data = BYTE_W'($urandom_range(0, 255));
    case ($urandom_range(0, 12))
      0: c.bus_addr = STUB_FIRST + ADDR_W'($urandom_range(0, 31));
      1: c.bus_addr = VEC_RESET_LO + ADDR_W'($urandom_range(0, 3));
      2: c.bus_addr = MULT_LO_ADDR + ADDR_W'($urandom_range(0, 1));
      3: c.bus_addr = MAP_FIRST + ADDR_W'($urandom_range(0, 9));
      4: c.bus_addr = DISK_FIRST - 16'd1 +
                      ADDR_W'($urandom_range(0, DISK_LAST - DISK_FIRST + 2));
      5: c.bus_addr = WTBL_FIRST - 16'd1 +
                      ADDR_W'($urandom_range(0, WTBL_LAST - WTBL_FIRST + 2));
      6: c.bus_addr = EXTP_FIRST - 16'd1 +
                      ADDR_W'($urandom_range(0, EXTP_LAST - EXTP_FIRST + 2));
      7: c.bus_addr = PULSE1_FIRST + ADDR_W'(16'h1000 * $urandom_range(0, 2)) +
                      ADDR_W'($urandom_range(0, 4));
      8: c.bus_addr = $urandom_range(0, 1) ? FM_ADDR_A : FM_ADDR_B;
      9: c.bus_addr = PSG_FIRST - 16'd1 + ADDR_W'($urandom_range(0, 16'h4000));
      10: c.bus_addr = IRQ_ACK_ADDR;
      default: c.bus_addr = ADDR_W'($urandom_range(0, 65535));
    endcase
    return c;
  endfunction

  task automatic push_cycle(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                            input logic [BYTE_W-1:0] data);
    item_t c;
    c.command = cmd;
    c.bus_addr = addr;
    c.write_data = data;
    cpu_cycles_todo.push_back(c);
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_cycle(CMD_TICK, ADDR_W'($urandom_range(0, 65535)),
                          BYTE_W'($urandom_range(0, 255)));
  endtask

  // Write one register; only called while no beat is in flight
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_CHIP_MASK:    regs.chip_mask    = val[CHIP_MASK_W-1:0];
      REG_PLAY_PERIOD:  regs.play_period  = val;
      REG_INIT_ADDRESS: regs.init_address = val;
      REG_PLAY_ADDRESS: regs.play_address = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [CHIP_MASK_W-1:0] mask, input logic [PERIOD_W-1:0] period,
                          input logic [ADDR_W-1:0] init_a, input logic [ADDR_W-1:0] play_a);
    write_reg(REG_CHIP_MASK, CFG_DATA_W'(mask));
    write_reg(REG_PLAY_PERIOD, period);
    write_reg(REG_INIT_ADDRESS, init_a);
    write_reg(REG_PLAY_ADDRESS, play_a);
    settings_used++;
    @(negedge clk);
  endtask

  // Wait until every queued cycle is accepted and every decode has come back
  task automatic drain();
    while (cpu_cycles_todo.size() != 0 || cpu_req.valid || predicted_decodes.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Drive request beats in bursts with random gaps; predict each accepted beat
  item_t nxt;
  int    burst_left;
  int    gap_left;

  always @(posedge clk) begin
    if (rst) begin
      cpu_req.valid      <= 1'b0;
      cpu_req.command    <= CMD_TICK;
      cpu_req.bus_addr   <= '0;
      cpu_req.write_data <= '0;
      burst_left <= 8;
      gap_left   <= 0;
    end else begin
      if (cpu_req.valid && cpu_req.ready)
        predicted_decodes.push_back(decode_cpu_cycle({cpu_req.command, cpu_req.bus_addr,
                                                      cpu_req.write_data}));
      if (!cpu_req.valid || cpu_req.ready) begin
        if (cpu_cycles_todo.size() != 0 && (calm || gap_left == 0)) begin
          nxt = cpu_cycles_todo.pop_front();
          cpu_req.valid      <= 1'b1;
          cpu_req.command    <= nxt.command;
          cpu_req.bus_addr   <= nxt.bus_addr;
          cpu_req.write_data <= nxt.write_data;
          if (!calm) begin
            if (burst_left <= 1) begin
              burst_left <= $urandom_range(1, 16);
              gap_left   <= $urandom_range(0, 6);
            end else begin
              burst_left <= burst_left - 1;
            end
          end
        end else begin
          cpu_req.valid <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end
      end
    end
  end

  // Response ready: own stall pattern, one long hold-off when armed
  logic [15:0] stall_lfsr;
  int          hold_left;
  logic        hold_done;

  always @(posedge clk) begin
    if (rst) begin
      dec_rsp.ready <= 1'b0;
      stall_lfsr    <= 16'hACE1;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (hold_left != 0) begin
      dec_rsp.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      dec_rsp.ready <= 1'b0;
      hold_left     <= LONG_HOLD;
      hold_done     <= 1'b1;
    end else if (calm) begin
      dec_rsp.ready <= 1'b1;
    end else begin
      stall_lfsr <= {stall_lfsr[14:0],
                     stall_lfsr[15] ^ stall_lfsr[13] ^ stall_lfsr[12] ^ stall_lfsr[10]};
      dec_rsp.ready <= !(stall_lfsr[0] && stall_lfsr[5]) && !(stall_lfsr[9:7] == 3'b111);
    end
  end

  // Compare each response beat with the oldest predicted decode
  result_t seen;
  result_t want;
  logic    last_irq;

  always @(posedge clk) begin
    if (rst) begin
      last_irq = 1'b0;
    end else if (dec_rsp.valid && dec_rsp.ready) begin
      seen = {dec_rsp.route, dec_rsp.read_data, dec_rsp.irq_line, dec_rsp.map_valid,
              dec_rsp.map_slot, dec_rsp.map_bank, dec_rsp.map_writable, dec_rsp.stub_offset};
      if (predicted_decodes.size() == 0) begin
        $error("response beat with no decode pending: route 0x%0h", seen.route);
        mismatches++;
      end else begin
        want = predicted_decodes.pop_front();
        check_field("route", 16'(want.route), 16'(seen.route));
        check_field("read_data", 16'(want.read_data), 16'(seen.read_data));
        check_field("irq_line", 16'(want.irq_line), 16'(seen.irq_line));
        check_field("map_valid", 16'(want.map_valid), 16'(seen.map_valid));
        check_field("map_slot", 16'(want.map_slot), 16'(seen.map_slot));
        check_field("map_bank", 16'(want.map_bank), 16'(seen.map_bank));
        check_field("map_writable", 16'(want.map_writable), 16'(seen.map_writable));
        check_field("stub_offset", 16'(want.stub_offset), 16'(seen.stub_offset));
      end
      if (seen.irq_line === 1'b1 && !last_irq) irq_rises++;
      last_irq = (seen.irq_line === 1'b1);
      decodes_checked++;
    end
  end

  // Stimulus
  initial begin
    int n;
    logic [BYTE_W-1:0] d;
    rst = 1'b1;
    calm = 1'b0;
    hold_arm = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_CHIP_MASK;
    cfg_data = '0;
    mismatches = 0;
    decodes_checked = 0;
    irq_rises = 0;
    bank_maps = 0;
    settings_used = 1;
    regs.chip_mask    = '0;
    regs.play_period  = PLAY_PERIOD_RESET;
    regs.init_address = ENTRY_ADDR_RESET;
    regs.play_address = ENTRY_ADDR_RESET;
    cart.play_countdown = PLAY_PERIOD_RESET;
    cart.irq_pending    = 1'b0;
    cart.mult_left      = '0;
    cart.mult_right     = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: no sound chips, so ticks, stub, vectors, bank writes, the acknowledge and unclaimed cycles
    push_cycle(CMD_TICK, 16'hFFFF, 8'hFF);
    push_cycle(CMD_READ, STUB_FIRST, 8'h00);
    push_cycle(CMD_READ, STUB_FIRST + STUB_INIT_LO, 8'h00);
    push_cycle(CMD_READ, STUB_FIRST + STUB_INIT_HI, 8'h00);
    push_cycle(CMD_READ, STUB_FIRST + STUB_PLAY_LO, 8'h00);
    push_cycle(CMD_READ, STUB_FIRST + STUB_PLAY_HI, 8'h00);
    push_cycle(CMD_READ, STUB_FIRST + STUB_PLAY2_LO, 8'h00);
    push_cycle(CMD_READ, STUB_FIRST + STUB_PLAY2_HI, 8'h00);
    push_cycle(CMD_READ, STUB_LAST, 8'h00);
    push_cycle(CMD_READ, VEC_RESET_LO, 8'h00);
    push_cycle(CMD_READ, VEC_RESET_HI, 8'h00);
    push_cycle(CMD_READ, VEC_IRQ_LO, 8'h00);
    push_cycle(CMD_READ, VEC_IRQ_HI, 8'h00);
    push_cycle(CMD_WRITE, MULT_LO_ADDR, 8'hFF);
    push_cycle(CMD_READ, MULT_LO_ADDR, 8'h00);
    push_cycle(CMD_READ, DISK_FIRST, 8'h00);
    push_cycle(CMD_WRITE, MAP_FIRST, 8'hFF);
    push_cycle(CMD_WRITE, MAP_LAST_RW, 8'h5A);
    push_cycle(CMD_WRITE, MAP_LAST, 8'h00);
    push_cycle(CMD_WRITE, IRQ_ACK_ADDR, 8'hA5);
    push_cycle(CMD_UNUSED, 16'hFFFF, 8'hFF);
    push_cycle(CMD_READ, 16'h0000, 8'h00);
    drain();

    // Every chip enabled, address extremes, period of one
    set_regs(6'h3F, 16'd1, 16'hFFFF, 16'h0000);
    push_cycle(CMD_READ, DISK_FIRST, 8'h00);
    push_cycle(CMD_READ, DISK_LAST, 8'h00);
    push_cycle(CMD_READ, WTBL_FIRST, 8'h00);
    push_cycle(CMD_READ, WTBL_LAST, 8'h00);
    push_cycle(CMD_WRITE, EXTP_FIRST, 8'h11);
    push_cycle(CMD_WRITE, EXTP_LAST, 8'h22);
    push_cycle(CMD_WRITE, WTBL_HIGH, 8'h33);
    push_cycle(CMD_WRITE, PSG_FIRST, 8'h44);
    push_cycle(CMD_WRITE, MULT_LO_ADDR, 8'hFF);
    push_cycle(CMD_WRITE, MULT_HI_ADDR, 8'hFF);
    push_cycle(CMD_READ, MULT_LO_ADDR, 8'h00);
    push_cycle(CMD_READ, MULT_HI_ADDR, 8'h00);
    push_cycle(CMD_WRITE, MAP_FIRST + 16'd2, 8'h80);
    push_cycle(CMD_WRITE, MAP_LAST_RW, 8'h7F);
    push_cycle(CMD_WRITE, MAP_LAST, 8'h01);
    push_cycle(CMD_WRITE, PULSE1_FIRST, 8'h55);
    push_cycle(CMD_WRITE, PULSE3_LAST, 8'h66);
    push_cycle(CMD_WRITE, FM_ADDR_B, 8'h77);
    push_cycle(CMD_READ, STUB_FIRST + STUB_INIT_LO, 8'h00);
    push_cycle(CMD_READ, STUB_FIRST + STUB_PLAY2_HI, 8'h00);
    push_cycle(CMD_READ, VEC_IRQ_HI, 8'h00);
    drain();

    // Random phases under several settings
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: set_regs(6'h3F, 16'd3, ADDR_W'($urandom_range(0, 65535)),
                    ADDR_W'($urandom_range(0, 65535)));
        1: set_regs(6'h00, 16'd1, 16'hFFFF, 16'h0000);
        default: set_regs(CHIP_MASK_W'($urandom_range(0, 63)),
                          PERIOD_W'($urandom_range(1, 12)),
                          ADDR_W'($urandom_range(0, 65535)),
                          ADDR_W'($urandom_range(0, 65535)));
      endcase
      n = 0;
      while (n < PHASE_CYCLES) begin
        case ($urandom_range(0, 9))
          0: begin
            // Load both multiplier operands, then read the product back
            d = BYTE_W'($urandom_range(0, 255));
            push_cycle(CMD_WRITE, MULT_LO_ADDR, d);
            push_cycle(CMD_WRITE, MULT_HI_ADDR, BYTE_W'($urandom_range(0, 255)));
            push_cycle(CMD_READ, MULT_LO_ADDR, BYTE_W'($urandom_range(0, 255)));
            push_cycle(CMD_READ, MULT_HI_ADDR, BYTE_W'($urandom_range(0, 255)));
            n += 4;
          end
          1: begin
            // Run a few ticks, then acknowledge the play interrupt
            d = BYTE_W'($urandom_range(1, 16));
            push_ticks(int'(d));
            push_cycle(CMD_WRITE, IRQ_ACK_ADDR, BYTE_W'($urandom_range(0, 255)));
            n += int'(d) + 1;
          end
          default: begin
            cpu_cycles_todo.push_back(random_cpu_cycle());
            n++;
          end
        endcase
      end
      if (phase == 0) hold_arm = 1'b1;
      drain();
    end

    // Zero period: only picked up at the next reload, so ticks keep counting down
    set_regs(regs.chip_mask, 16'd0, regs.init_address, regs.play_address);
    calm = 1'b1;
    push_ticks(8);
    push_cycle(CMD_WRITE, IRQ_ACK_ADDR, 8'h00);
    push_cycle(CMD_READ, STUB_FIRST + STUB_PLAY_LO, 8'h00);
    drain();
    calm = 1'b0;

    // Longest period, random chips
    set_regs(CHIP_MASK_W'($urandom_range(0, 63)), 16'hFFFF,
             ADDR_W'($urandom_range(0, 65535)), ADDR_W'($urandom_range(0, 65535)));
    repeat (40) cpu_cycles_todo.push_back(random_cpu_cycle());
    drain();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Checked %0d decodes under %0d register settings, %0d bank mappings.",
             decodes_checked, settings_used, bank_maps);
    $display("Saw %0d interrupt rises; bursts, gaps and one long response hold-off.",
             irq_rises);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #(RUN_LIMIT_NS);
    $display("Timed out with %0d decodes outstanding.", predicted_decodes.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
